FILE: hdl/nlb_pkg.sv
`default_nettype none
package nlb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int OCOL_W  = 10;
  localparam int POS_W   = 12;
  localparam int WID_W   = 13;
  localparam int RAD_W   = 4;
  localparam int SLOT_W  = 6;
  localparam int K_W     = 12;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [10:0]          RST_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0]     RST_HEIGHT = 12'd480;
  localparam logic [2:0]           RST_RADIUS = 3'd7;
  localparam logic signed [K_W-1:0] RST_KGAIN = -12'sd51;
  localparam logic                 RST_MIXED  = 1'b0;
  localparam logic [PIX_W-1:0]     RST_FLOOR  = 8'd0;

  typedef enum logic [CFG_AW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_KGAIN  = 3'd3,
    REG_MIXED  = 3'd4,
    REG_FLOOR  = 3'd5
  } cfg_reg_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic [WID_W-1:0]       width;
    logic [ROW_W-1:0]       height;
    logic [RAD_W-1:0]       radius;
    logic signed [K_W-1:0]  k_gain;
    logic                   mixed;
    logic [PIX_W-1:0]       global_floor;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } job_t;

  typedef struct packed {
    logic              white;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic [PIX_W-1:0]  thr;
    logic              eoi;
  } result_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CTR, B_WIN, B_TAIL, B_MUL, B_DIVM, B_WAITM,
    B_DIVV, B_WAITV, B_SQRT, B_KMUL, B_THR, B_DONE
  } back_state_t;

endpackage
`default_nettype wire

FILE: hdl/nlb_if.sv
`default_nettype none
interface nlb_pix_if;
  import nlb_pkg::*;
  logic             valid;
  logic             ready;
  logic             command;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output command, output pixel, input ready);
  modport sink (input valid, input command, input pixel, output ready);
endinterface

interface nlb_res_if;
  import nlb_pkg::*;
  logic              valid;
  logic              ready;
  logic              out_white;
  logic [ROW_W-1:0]  out_row;
  logic [OCOL_W-1:0] out_col;
  logic [PIX_W-1:0]  local_threshold;
  logic              end_of_image;
  modport source (output valid, output out_white, output out_row, output out_col,
                  output local_threshold, output end_of_image, input ready);
  modport sink (input valid, input out_white, input out_row, input out_col,
                input local_threshold, input end_of_image, output ready);
endinterface
`default_nettype wire

FILE: hdl/nlb_ram.sv
`default_nettype none
module nlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hdl/nlb_queue.sv
`default_nettype none
module nlb_queue #(
  parameter int DEPTH = nlb_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire nlb_pkg::job_t din,
  input  wire logic          pop,
  output nlb_pkg::job_t      dout,
  output logic               full,
  output logic               not_empty
);
  import nlb_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNTW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(DEPTH)) else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("job popped from empty queue");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1) else $error("pop lost");
`endif

endmodule
`default_nettype wire

FILE: hdl/nlb_div.sv
`default_nettype none
module nlb_div #(
  parameter int DVW = 48,
  parameter int DSW = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                done,
  output logic      [DVW-1:0] quotient
);

  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DVW-1:0]  quo_r, quo_nxt;
  logic [DSW-1:0]  rem_r, rem_nxt;
  logic [DSW-1:0]  dvs_r, dvs_nxt;
  logic [DSW:0]    shifted;
  logic            fits;

  assign shifted = {rem_r, quo_r[DVW-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(DVW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // one quotient bit a cycle, most significant first
      rem_nxt = fits ? DSW'(shifted - {1'b0, dvs_r}) : DSW'(shifted);
      quo_nxt = {quo_r[DVW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: hdl/nlb_front.sv
`default_nettype none
module nlb_front #(
  parameter int MAX_WIDTH  = nlb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = nlb_pkg::DEF_MAX_RADIUS,
  parameter int AW         = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  nlb_pix_if.sink                         in_bus,
  input  wire logic                       cfg_we,
  input  wire logic [nlb_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [nlb_pkg::CFG_DW-1:0] cfg_wdata,
  output nlb_pkg::cfg_t                   cfg,
  output logic                            ram_we,
  output logic [AW-1:0]                   ram_waddr,
  output logic [nlb_pkg::PIX_W-1:0]       ram_wdata,
  input  wire logic                       q_full,
  output logic                            q_push,
  output nlb_pkg::job_t                   q_job
);
  import nlb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RB = AW - CW;

  logic [10:0]           width_r;
  logic [ROW_W-1:0]      height_r;
  logic [2:0]            radius_r;
  logic signed [K_W-1:0] kgain_r;
  logic                  mixed_r;
  logic [PIX_W-1:0]      floor_r;

  logic [ROW_W-1:0] in_row_r, in_row_nxt, em_row_r, em_row_nxt;
  logic [CW-1:0]    in_col_r, in_col_nxt, em_col_r, em_col_nxt;
  logic [RB-1:0]    in_slot_r, in_slot_nxt, em_slot_r, em_slot_nxt;
  logic             done_r, done_nxt;

  logic [WID_W-1:0] eff_w, wm1, ecp, nc;
  logic [ROW_W-1:0] eff_h, hm1, nr;
  logic [ROW_W:0]   erp;
  logic [RAD_W-1:0] eff_r;
  logic             accept, store, col_end, row_end, ready, last, cfg_hit;
  logic [ROW_W-1:0] prow;
  logic [CW-1:0]    pcol;
  logic [RB-1:0]    pslot;
  logic             pdone;

  always_comb begin
    if (width_r == '0) begin
      eff_w = WID_W'(1);
    end else if (WID_W'(width_r) > WID_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(width_r);
    end
    eff_h = (height_r == '0) ? ROW_W'(1) : height_r;
    eff_r = (RAD_W'(radius_r) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                    : RAD_W'(radius_r);
  end

  assign cfg = '{width: eff_w, height: eff_h, radius: eff_r, k_gain: kgain_r,
                 mixed: mixed_r, global_floor: floor_r};

  assign in_bus.ready = !q_full;
  assign accept  = in_bus.valid && !q_full;
  assign store   = accept && (in_bus.command == CMD_PIXEL) && !done_r;
  assign wm1     = eff_w - 1'b1;
  assign hm1     = eff_h - 1'b1;
  assign col_end = WID_W'(in_col_r) == wm1;
  assign row_end = in_row_r == hm1;

  // position after this word's pixel is stored
  always_comb begin
    prow  = in_row_r;
    pcol  = in_col_r;
    pslot = in_slot_r;
    pdone = done_r;
    if (store) begin
      if (!col_end) begin
        pcol = in_col_r + 1'b1;
      end else begin
        pcol = '0;
        if (!row_end) begin
          prow  = in_row_r + 1'b1;
          pslot = in_slot_r + 1'b1;
        end else begin
          pdone = 1'b1;
        end
      end
    end
  end

  always_comb begin
    erp   = {1'b0, em_row_r} + (ROW_W + 1)'(eff_r);
    nr    = (erp > {1'b0, hm1}) ? hm1 : erp[ROW_W-1:0];
    ecp   = WID_W'(em_col_r) + WID_W'(eff_r);
    nc    = (ecp > wm1) ? wm1 : ecp;
    ready = pdone || (prow > nr) || ((prow == nr) && (WID_W'(pcol) > nc));
    last  = (em_row_r == hm1) && (WID_W'(em_col_r) == wm1);
  end

  assign q_push = accept && ready;
  assign q_job  = '{row: em_row_r, col: POS_W'(em_col_r), slot: SLOT_W'(em_slot_r),
                    last: last};

  assign ram_we    = store;
  assign ram_waddr = {in_slot_r, in_col_r};
  assign ram_wdata = in_bus.pixel;

  assign cfg_hit = cfg_we && (cfg_addr <= REG_FLOOR);

  always_comb begin
    in_row_nxt  = prow;
    in_col_nxt  = pcol;
    in_slot_nxt = pslot;
    done_nxt    = pdone;
    em_row_nxt  = em_row_r;
    em_col_nxt  = em_col_r;
    em_slot_nxt = em_slot_r;
    if (cfg_hit) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      in_slot_nxt = '0;
      done_nxt    = 1'b0;
      em_row_nxt  = '0;
      em_col_nxt  = '0;
      em_slot_nxt = '0;
    end else if (q_push) begin
      if (last) begin
        // new image starts on the ring row after the last one decided
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        in_slot_nxt = em_slot_r + 1'b1;
        done_nxt    = 1'b0;
        em_row_nxt  = '0;
        em_col_nxt  = '0;
        em_slot_nxt = em_slot_r + 1'b1;
      end else if (WID_W'(em_col_r) == wm1) begin
        em_col_nxt  = '0;
        em_row_nxt  = em_row_r + 1'b1;
        em_slot_nxt = em_slot_r + 1'b1;
      end else begin
        em_col_nxt = em_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RST_WIDTH;
      height_r  <= RST_HEIGHT;
      radius_r  <= RST_RADIUS;
      kgain_r   <= RST_KGAIN;
      mixed_r   <= RST_MIXED;
      floor_r   <= RST_FLOOR;
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_slot_r <= '0;
      done_r    <= 1'b0;
      em_row_r  <= '0;
      em_col_r  <= '0;
      em_slot_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_WIDTH:  width_r  <= cfg_wdata[10:0];
          REG_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
          REG_RADIUS: radius_r <= cfg_wdata[2:0];
          REG_KGAIN:  kgain_r  <= $signed(cfg_wdata[K_W-1:0]);
          REG_MIXED:  mixed_r  <= cfg_wdata[0];
          REG_FLOOR:  floor_r  <= cfg_wdata[PIX_W-1:0];
          default: ;
        endcase
      end
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      in_slot_r <= in_slot_nxt;
      done_r    <= done_nxt;
      em_row_r  <= em_row_nxt;
      em_col_r  <= em_col_nxt;
      em_slot_r <= em_slot_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/nlb_back.sv
`default_nettype none
module nlb_back #(
  parameter int MAX_WIDTH  = nlb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = nlb_pkg::DEF_MAX_RADIUS,
  parameter int AW         = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire nlb_pkg::cfg_t         cfg,
  input  wire logic                  job_valid,
  input  wire nlb_pkg::job_t         job,
  output logic                       job_pop,
  output logic [AW-1:0]              ram_raddr,
  input  wire logic [nlb_pkg::PIX_W-1:0] ram_rdata,
  nlb_res_if.source                  out_bus
);
  import nlb_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RB   = AW - CW;
  localparam int WIN  = 2 * MAX_RADIUS + 1;
  localparam int NMAX = WIN * WIN;
  localparam int NW   = $clog2(NMAX + 1);
  localparam int SW   = NW + 8;
  localparam int QW   = NW + 16;
  localparam int NQW  = NW + QW;
  localparam int DSW  = 2 * NW;
  localparam int DVW  = NQW + 16;
  localparam int VW   = 32;
  localparam int MW   = 16;
  localparam int KDW  = K_W + MW + 1;
  localparam int TW   = KDW + 1;

  back_state_t state_r, state_nxt;

  logic [ROW_W-1:0] y_r, r1_r, row_r;
  logic [CW-1:0]    x_r, c0_r, c1_r, col_r;
  logic [RB-1:0]    y_slot_r, ctr_slot_r;
  logic             last_r, ctr_v_r, acc_v_r;
  logic [PIX_W-1:0] pix_r;
  logic [SW-1:0]    sum_r;
  logic [QW-1:0]    sq_r;
  logic [NW-1:0]    n_r;
  logic [NQW-1:0]   nq_r, ss_r;
  logic [DSW-1:0]   nn_r;
  logic [MW-1:0]    mean_r;
  logic [VW-1:0]    v_r, root_r, bit_r;
  logic signed [KDW-1:0] kd_r;
  logic [PIX_W-1:0] thr_r;
  logic             white_r;
  result_t          res_r;
  logic             out_v_r, out_v_nxt;

  logic [ROW_W-1:0] er, r0, r1, hm1;
  logic [ROW_W:0]   erp;
  logic [WID_W-1:0] ecw, ecp, wm1;
  logic [CW-1:0]    c0, c1;
  logic [15:0]      sq_term;
  logic [VW-1:0]    trial;
  logic signed [TW-1:0] t_full;
  logic [PIX_W-1:0] thr_c;

  logic           div_start, div_done, out_free, out_load, win_end;
  logic [DVW-1:0] div_dividend, div_quo;
  logic [DSW-1:0] div_divisor;

  nlb_div #(.DVW(DVW), .DSW(DSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // clipped window bounds of the job at the head of the queue
  always_comb begin
    er  = job.row;
    hm1 = cfg.height - 1'b1;
    wm1 = cfg.width - 1'b1;
    r0  = (er > ROW_W'(cfg.radius)) ? er - ROW_W'(cfg.radius) : '0;
    erp = {1'b0, er} + (ROW_W + 1)'(cfg.radius);
    r1  = (erp > {1'b0, hm1}) ? hm1 : erp[ROW_W-1:0];
    ecw = WID_W'(job.col);
    c0  = (ecw > WID_W'(cfg.radius)) ? CW'(ecw - WID_W'(cfg.radius)) : '0;
    ecp = ecw + WID_W'(cfg.radius);
    c1  = (ecp > wm1) ? CW'(wm1) : CW'(ecp);
  end

  assign win_end  = (y_r == r1_r) && (x_r == c1_r);
  assign out_free = !out_v_r || out_bus.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (job_valid) state_nxt = B_CTR;
      B_CTR:   state_nxt = B_WIN;
      B_WIN:   if (win_end) state_nxt = B_TAIL;
      B_TAIL:  state_nxt = B_MUL;
      B_MUL:   state_nxt = B_DIVM;
      B_DIVM:  state_nxt = B_WAITM;
      B_WAITM: if (div_done) state_nxt = B_DIVV;
      B_DIVV:  state_nxt = B_WAITV;
      B_WAITV: if (div_done) state_nxt = B_SQRT;
      B_SQRT:  if (bit_r == VW'(1)) state_nxt = B_KMUL;
      B_KMUL:  state_nxt = B_THR;
      B_THR:   state_nxt = B_DONE;
      B_DONE:  if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop      = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    div_dividend = DVW'({sum_r, 8'b0});
    div_divisor  = DSW'(n_r);
    ram_raddr    = {y_slot_r, x_r};
    case (state_r)
      B_IDLE: job_pop = job_valid;
      B_CTR:  ram_raddr = {ctr_slot_r, col_r};
      B_DIVM: div_start = 1'b1;
      B_DIVV: begin
        div_start    = 1'b1;
        div_dividend = {NQW'(nq_r - ss_r), 16'b0};
        div_divisor  = nn_r;
      end
      B_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign sq_term = {8'b0, ram_rdata} * {8'b0, ram_rdata};
  assign trial   = root_r + bit_r;
  assign t_full  = $signed({(TW - MW - 8)'(0), mean_r, 8'b0}) + TW'(kd_r);

  always_comb begin
    if (t_full[TW-1]) begin
      thr_c = '0;
    end else if (|t_full[TW-2:24]) begin
      thr_c = PIX_MAX;
    end else begin
      thr_c = t_full[23:16];
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_v_r <= 1'b0;
      ctr_v_r <= 1'b0;
      acc_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
      ctr_v_r <= (state_r == B_CTR);
      acc_v_r <= (state_r == B_WIN);
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      row_r      <= job.row;
      col_r      <= CW'(job.col);
      last_r     <= job.last;
      ctr_slot_r <= RB'(job.slot);
      y_slot_r   <= RB'(job.slot) - RB'(er - r0);
      y_r        <= r0;
      r1_r       <= r1;
      x_r        <= c0;
      c0_r       <= c0;
      c1_r       <= c1;
      sum_r      <= '0;
      sq_r       <= '0;
      n_r        <= '0;
    end else begin
      if (state_r == B_WIN && !win_end) begin
        if (x_r == c1_r) begin
          x_r      <= c0_r;
          y_r      <= y_r + 1'b1;
          y_slot_r <= y_slot_r + 1'b1;
        end else begin
          x_r <= x_r + 1'b1;
        end
      end
      if (acc_v_r) begin
        sum_r <= sum_r + SW'(ram_rdata);
        sq_r  <= sq_r + QW'(sq_term);
        n_r   <= n_r + 1'b1;
      end
    end
    if (ctr_v_r) begin
      pix_r <= ram_rdata;
    end
    if (state_r == B_MUL) begin
      nq_r <= NQW'(n_r) * NQW'(sq_r);
      ss_r <= NQW'(sum_r) * NQW'(sum_r);
      nn_r <= DSW'(n_r) * DSW'(n_r);
    end
    if (state_r == B_WAITM && div_done) begin
      mean_r <= MW'(div_quo);
    end
    if (state_r == B_WAITV && div_done) begin
      v_r    <= VW'(div_quo);
      root_r <= '0;
      bit_r  <= VW'(1) << (VW - 2);
    end
    if (state_r == B_SQRT) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (state_r == B_KMUL) begin
      kd_r <= cfg.k_gain * $signed({1'b0, root_r[MW-1:0]});
    end
    if (state_r == B_THR) begin
      thr_r   <= thr_c;
      white_r <= (pix_r > thr_c) && !(cfg.mixed && (pix_r <= cfg.global_floor));
    end
    if (out_load) begin
      res_r <= '{white: white_r, row: row_r, col: OCOL_W'(col_r), thr: thr_r,
                 eoi: last_r};
    end
  end

  assign out_bus.valid           = out_v_r;
  assign out_bus.out_white       = res_r.white;
  assign out_bus.out_row         = res_r.row;
  assign out_bus.out_col         = res_r.col;
  assign out_bus.local_threshold = res_r.thr;
  assign out_bus.end_of_image    = res_r.eoi;

endmodule
`default_nettype wire

FILE: hdl/niblack_local_binarize.sv
// Niblack local binarisation of a raster stream.
// in_bus carries one word per pixel (command 0) or a drain request (command 1);
// out_bus returns at most one decided pixel per word, in raster order, with its
// row, column, window threshold and an end-of-image flag. Results lag the input
// by r rows and r pixels; after the last pixel, drain words flush the rest.
// The front takes a word per cycle while its two-entry job queue has room,
// stores the pixel into a 32-row ring line store and queues a decision once the
// look-ahead pixels are in. The back decides one pixel at a time: one line-store
// read per window pixel, then a bit-serial divider for the mean and again for
// the variance, and a 16-step square root; clipped windows take fewer reads.
// That back-end loop sets the sustained rate; the front fills the queue ahead.
// A result sits in the output register until taken; while out_bus is stalled
// the back holds its finished result and the front keeps filling the queue.
// Reset clears all positions and loads width 640, height 480, radius 7,
// k = -51/256, mixed mode off and floor 0. The line store needs no clearing.
// A write to a defined configuration register restarts the stream; write only while the block idles.
`default_nettype none
module niblack_local_binarize #(
  parameter int MAX_WIDTH  = nlb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = nlb_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  nlb_pix_if.sink                         in_bus,
  nlb_res_if.source                       out_bus,
  input  wire logic                       cfg_we,
  input  wire logic [nlb_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [nlb_pkg::CFG_DW-1:0] cfg_wdata
);
  import nlb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(2 * MAX_RADIUS + 4);
  localparam int AW = RB + CW;

  cfg_t             cfg;
  job_t             push_job, head_job;
  logic             q_push, q_pop, q_full, q_valid, ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  nlb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  nlb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (push_job),
    .pop       (q_pop),
    .dout      (head_job),
    .full      (q_full),
    .not_empty (q_valid)
  );

  nlb_ram #(.WIDTH(PIX_W), .DEPTH(2 ** AW)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nlb_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (q_valid),
    .job       (head_job),
    .job_pop   (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_bus   (out_bus)
  );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
import nlb_pkg::*;

class binarize_scoreboard;
  localparam int RING = 16;
  localparam int MAXW = 1024;

  logic [7:0]  line_mem [0:RING*MAXW-1];
  int unsigned width_reg, height_reg, radius_reg;
  logic [11:0] k_reg;
  bit          mixed_reg;
  logic [7:0]  floor_reg;
  int unsigned in_r, in_c, dec_r, dec_c;
  bit          image_in;
  result_t     pending_decisions[$];
  int          errors;

  function new();
    width_reg = 640; height_reg = 480; radius_reg = 7; k_reg = 12'hFCD;
    mixed_reg = 0; floor_reg = 0; errors = 0;
    restart();
  endfunction

  function void restart();
    in_r = 0; in_c = 0; dec_r = 0; dec_c = 0; image_in = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [11:0] val);
    case (idx)
      REG_WIDTH:  width_reg  = val[10:0];
      REG_HEIGHT: height_reg = val;
      REG_RADIUS: radius_reg = val[2:0];
      REG_KGAIN:  k_reg      = val;
      REG_MIXED:  mixed_reg  = val[0];
      REG_FLOOR:  floor_reg  = val[7:0];
      default: return;
    endcase
    restart();
  endfunction

  function int unsigned eff_w();
    if (width_reg == 0) return 1;
    return (width_reg > MAXW) ? MAXW : width_reg;
  endfunction

  function int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function int unsigned slot_of(int unsigned row, int unsigned col);
    return (row % RING) * MAXW + (col % MAXW);
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0; bitv = 64'h1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function bit decision_ready();
    int unsigned nr, nc;
    if (image_in) return 1;
    nr = dec_r + radius_reg; if (nr > eff_h() - 1) nr = eff_h() - 1;
    nc = dec_c + radius_reg; if (nc > eff_w() - 1) nc = eff_w() - 1;
    return (in_r > nr) || (in_r == nr && in_c > nc);
  endfunction

  function void decide_pixel();
    int unsigned w, h, rad, r0, r1, c0, c1;
    longint unsigned sum, sq, n, mean, var_q, dev, thr, v;
    longint signed kval, t;
    logic [7:0] p;
    result_t res;
    w = eff_w(); h = eff_h(); rad = radius_reg;
    r0 = (dec_r > rad) ? dec_r - rad : 0;
    r1 = (dec_r + rad > h - 1) ? h - 1 : dec_r + rad;
    c0 = (dec_c > rad) ? dec_c - rad : 0;
    c1 = (dec_c + rad > w - 1) ? w - 1 : dec_c + rad;
    sum = 0; sq = 0; n = 0;
    for (int unsigned y = r0; y <= r1; y++)
      for (int unsigned x = c0; x <= c1; x++) begin
        v = line_mem[slot_of(y, x)];
        sum += v; sq += v * v; n++;
      end
    mean  = (sum << 8) / n;
    var_q = ((n * sq - sum * sum) << 16) / (n * n);
    dev   = int_sqrt(var_q);
    kval  = $signed(k_reg);
    t = longint'(mean << 8) + kval * longint'(dev);
    if (t < 0) thr = 0;
    else begin
      thr = t >>> 16;
      if (thr > 255) thr = 255;
    end
    p = line_mem[slot_of(dec_r, dec_c)];
    res.white = (p > thr);
    if (mixed_reg && p <= floor_reg) res.white = 0;
    res.row = dec_r[11:0];
    res.col = dec_c[9:0];
    res.thr = thr[7:0];
    res.eoi = (dec_r == h - 1) && (dec_c == w - 1);
    pending_decisions.push_back(res);
    if (res.eoi) restart();
    else if (dec_c + 1 < w) dec_c++;
    else begin
      dec_c = 0; dec_r++;
    end
  endfunction

  // note an accepted input word
  function void note_word(logic cmd, logic [7:0] pix);
    if (cmd == CMD_PIXEL && !image_in) begin
      line_mem[slot_of(in_r, in_c)] = pix;
      if (in_c + 1 < eff_w()) in_c++;
      else begin
        in_c = 0;
        if (in_r + 1 < eff_h()) in_r++;
        else image_in = 1;
      end
    end
    if (decision_ready()) decide_pixel();
  endfunction

  function void check_result(result_t got);
    result_t exp;
    if (pending_decisions.size() == 0) begin
      $error("unexpected result row %0d col %0d", got.row, got.col);
      errors++;
      return;
    end
    exp = pending_decisions.pop_front();
    if (got.white !== exp.white) begin
      $error("out_white exp %0d got %0d", exp.white, got.white); errors++;
    end
    if (got.row !== exp.row) begin
      $error("out_row exp %0d got %0d", exp.row, got.row); errors++;
    end
    if (got.col !== exp.col) begin
      $error("out_col exp %0d got %0d", exp.col, got.col); errors++;
    end
    if (got.thr !== exp.thr) begin
      $error("local_threshold exp %0d got %0d", exp.thr, got.thr); errors++;
    end
    if (got.eoi !== exp.eoi) begin
      $error("end_of_image exp %0d got %0d", exp.eoi, got.eoi); errors++;
    end
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE       = 400;
  localparam logic [2:0] REG_UNUSED = 3'd6;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  nlb_pix_if in_bus ();
  nlb_res_if out_bus ();

  binarize_scoreboard sb = new();
  bit no_idle = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int random_items = 0;

  niblack_local_binarize i_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    in_bus.valid = 0; in_bus.command = CMD_PIXEL; in_bus.pixel = '0;
    out_bus.ready = 0;
  end

  function int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 0;
    end else begin
      stall_left = pick_gap();
      out_bus.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.white = out_bus.out_white;
      got.row   = out_bus.out_row;
      got.col   = out_bus.out_col;
      got.thr   = out_bus.local_threshold;
      got.eoi   = out_bus.end_of_image;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(logic cmd, logic [7:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1;
    in_bus.command <= cmd;
    in_bus.pixel   <= pix;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_word(cmd, pix);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 0;
    while (sb.pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(int w, int h, int rad, int k, bit mix, int flr);
    logic [CFG_DW-1:0] vals [6];
    vals[0] = CFG_DW'(w); vals[1] = CFG_DW'(h); vals[2] = CFG_DW'(rad);
    vals[3] = CFG_DW'(k); vals[4] = CFG_DW'(mix); vals[5] = CFG_DW'(flr);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1; cfg_addr <= CFG_AW'(i); cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(3'(i), vals[i]);
    end
    if ($urandom_range(0, 3) == 0) begin
      cfg_addr <= REG_UNUSED; cfg_wdata <= CFG_DW'($urandom);
      @(posedge clk);
      sb.write_reg(REG_UNUSED, cfg_wdata);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function logic [7:0] pick_pixel(int mode);
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(100, 110));
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // feed a whole image, with stray drains; cut short when broken is set
  task automatic run_image(bit broken, bit counted);
    int total, stop_at, mode;
    total = sb.eff_w() * sb.eff_h();
    stop_at = broken ? $urandom_range(0, total - 1) : total;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(CMD_DRAIN, 8'($urandom));
        if (counted) random_items++;
      end
      send_word(CMD_PIXEL, pick_pixel(mode));
      if (counted) random_items++;
    end
    // flush; stray pixels here are discarded by the block
    while (!broken && sb.image_in) begin
      send_word($urandom_range(0, 4) == 0 ? CMD_PIXEL : CMD_DRAIN, 8'($urandom));
      if (counted) random_items++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // drains with nothing ready give nothing
    send_word(CMD_DRAIN, 8'hFF);
    send_word(CMD_DRAIN, 8'h00);
    wait_idle();

    // radius wider than the image, floor at top: all black
    write_config(3, 2, 7, 0, 1, 255);
    for (int i = 0; i < 6; i++) send_word(CMD_PIXEL, (i % 2) ? 8'd255 : 8'd0);
    send_word(CMD_PIXEL, 8'd255);
    while (sb.image_in) send_word(CMD_DRAIN, 8'd0);
    wait_idle();

    // zero width and height act as one
    write_config(0, 0, 0, 2047, 0, 0);
    send_word(CMD_PIXEL, 8'd128);
    send_word(CMD_DRAIN, 8'd0);
    wait_idle();

    no_idle = 1;
    write_config(4, 3, 1, 12'h800, 0, 0);
    send_word(CMD_PIXEL, 8'd255);
    for (int i = 0; i < 10; i++) send_word(CMD_PIXEL, 8'($urandom));
    send_word(CMD_PIXEL, 8'd0);
    while (sb.image_in) send_word(CMD_DRAIN, 8'd0);
    no_idle = 0;
    wait_idle();

    // oversize width; start of one long row
    write_config(2047, 1, 7, 12'h555, 1, 8'hAA);
    for (int i = 0; i < 40; i++) send_word(CMD_PIXEL, 8'($urandom));
    wait_idle();
    // tall single column, cut short
    no_idle = 1;
    write_config(1, 2049, 0, 12'h2AA, 0, 8'h55);
    for (int i = 0; i < 40; i++) send_word(CMD_PIXEL, 8'($urandom));
    no_idle = 0;
    wait_idle();

    while (random_items < 300) begin
      no_idle = ($urandom_range(0, 4) == 0);
      write_config($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 7),
                   $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 255));
      run_image($urandom_range(0, 9) == 0, 1);
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
